### design/sfc_pkg.sv
// Shared types, constants and helpers for the sensor filter chain.
`timescale 1ns / 1ps
`default_nettype none
package sfc_pkg;

  // sample and configuration widths
  localparam int SAMPLE_W   = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;
  localparam int KIND_W     = 3;
  localparam int USED_W     = 3;
  localparam int CNT_W      = 4;
  localparam int PROD_W     = 40;
  localparam int LEV_W      = 18;

  // default chain length and number of stage kind registers
  localparam int NUM_STAGES_DEF = 4;
  localparam int KIND_REGS      = 4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [LEV_W-1:0]    lev_t;
  typedef logic [CNT_W-1:0]           cnt_t;
  typedef logic [KIND_W-1:0]          kind_t;
  typedef logic [USED_W-1:0]          used_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

  // register indexes
  localparam cfg_idx_t REG_STAGES_USED = 8'd0;
  localparam cfg_idx_t REG_KIND_0      = 8'd1;

  // stage kinds; the two unused codes behave as bypass
  localparam kind_t KIND_BYPASS = 3'd0;
  localparam kind_t KIND_CHEB   = 3'd1;
  localparam kind_t KIND_BESSEL = 3'd2;
  localparam kind_t KIND_MEDIAN = 3'd3;
  localparam kind_t KIND_FAST   = 3'd4;
  localparam kind_t KIND_SMOOTH = 3'd5;

  // low-pass coefficients, rounding terms and shifts
  localparam prod_t K_CHEB_A = 40'sd3269048;
  localparam prod_t K_CHEB_B = 40'sd3701023;
  localparam prod_t RND_CHEB = 40'sd1048576;
  localparam int    SA_CHEB  = 2;
  localparam int    SB_CHEB  = 3;
  localparam int    SR_CHEB  = 21;
  localparam prod_t K_BES_A  = 40'sd2057199;
  localparam prod_t K_BES_B  = 40'sd1068552;
  localparam prod_t RND_BES  = 40'sd524288;
  localparam int    SA_BES   = 3;
  localparam int    SB_BES   = 1;
  localparam int    SR_BES   = 20;

  // tracker steps
  localparam int   FAST_STEPS = 4;
  localparam lev_t FAST_STEP [FAST_STEPS] = '{18'sd512, 18'sd128, 18'sd32, 18'sd8};
  localparam lev_t SMOOTH_GAP = 18'sd8;
  localparam lev_t LEV_ONE    = 18'sd1;
  localparam cnt_t CNT_WRAP   = 4'd10;

  localparam prod_t SAMPLE_MAX = 40'sd32767;
  localparam prod_t SAMPLE_MIN = -40'sd32768;

  // word handed from cell to cell
  typedef struct packed {
    logic    valid;
    sample_t x;
  } tok_t;

  // per-cell control from the top level
  typedef struct packed {
    logic  adv;
    logic  act;
    kind_t kind;
  } cell_ctl_t;

  // clamp a wide signed value to 16 bits
  function automatic sample_t sat16(input prod_t v);
    sample_t r;
    if (v > SAMPLE_MAX) begin
      r = sample_t'(SAMPLE_MAX[SAMPLE_W-1:0]);
    end else if (v < SAMPLE_MIN) begin
      r = sample_t'(SAMPLE_MIN[SAMPLE_W-1:0]);
    end else begin
      r = sample_t'(v[SAMPLE_W-1:0]);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### design/sfc_if.sv
// Channel interfaces: sample input, sample output and configuration write.
`timescale 1ns / 1ps
`default_nettype none
interface sfc_in_if;
  import sfc_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface sfc_out_if;
  import sfc_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

interface sfc_cfg_if;
  import sfc_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### design/sfc_cell.sv
// One filter cell: product phase, then finish phase with local state update.
`timescale 1ns / 1ps
`default_nettype none
module sfc_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  sfc_pkg::cell_ctl_t ctl,
  input  sfc_pkg::tok_t      up,
  output sfc_pkg::tok_t      dn,
  output logic              a_busy
);
  import sfc_pkg::*;

  // phase A: word waiting for its products
  logic    va_r;
  sample_t xa_r;
  // phase B: products ready, finish and update
  logic    vb_r;
  sample_t xb_r;
  prod_t   pa_r, pb_r;
  prod_t   pa_nxt, pb_nxt;

  // stage state
  sample_t h0_r, h1_r, h2_r, lvl_r;
  cnt_t    cnt_r;
  sample_t h0_nxt, h1_nxt, h2_nxt, lvl_nxt;
  cnt_t    cnt_nxt;

  sample_t y;
  logic    bes;

  // products for the low-pass kinds
  always_comb begin
    bes    = (ctl.kind == KIND_BESSEL);
    pa_nxt = prod_t'(xa_r) * (bes ? K_BES_A : K_CHEB_A);
    pb_nxt = prod_t'(h1_r) * (bes ? K_BES_B : K_CHEB_B);
  end

  // finish phase
  always_comb begin
    prod_t   sum;
    sample_t v1;
    sample_t med;
    lev_t    h;
    lev_t    xe;
    cnt_t    c;
    sum = '0;
    v1  = '0;
    med = '0;
    h   = lev_t'(lvl_r);
    xe  = lev_t'(xb_r);
    c   = cnt_r;
    h0_nxt  = h0_r;
    h1_nxt  = h1_r;
    h2_nxt  = h2_r;
    lvl_nxt = lvl_r;
    cnt_nxt = cnt_r;
    y       = xb_r;
    case (ctl.kind)
      KIND_CHEB, KIND_BESSEL: begin
        if (bes) begin
          sum = (pa_r >>> SA_BES) + (pb_r >>> SB_BES) + RND_BES;
          v1  = sat16(sum >>> SR_BES);
        end else begin
          sum = (pa_r >>> SA_CHEB) + (pb_r >>> SB_CHEB) + RND_CHEB;
          v1  = sat16(sum >>> SR_CHEB);
        end
        h0_nxt = h1_r;
        h1_nxt = v1;
        y      = sat16(prod_t'(h1_r) + prod_t'(v1));
      end
      KIND_MEDIAN: begin
        // window is old v1, old v2, new sample
        if ((h1_r <= h2_r && h2_r <= xb_r) || (xb_r <= h2_r && h2_r <= h1_r)) begin
          med = h2_r;
        end else if ((h2_r <= h1_r && h1_r <= xb_r) ||
                     (xb_r <= h1_r && h1_r <= h2_r)) begin
          med = h1_r;
        end else begin
          med = xb_r;
        end
        h0_nxt = h1_r;
        h1_nxt = h2_r;
        h2_nxt = xb_r;
        y      = med;
      end
      KIND_FAST: begin
        // coarse to fine steps toward the sample, then one unit
        if (xe > h) begin
          for (int i = 0; i < FAST_STEPS; i++) begin
            if (xe > h + FAST_STEP[i]) h = h + FAST_STEP[i];
          end
          h = h + LEV_ONE;
        end else if (xe < h) begin
          for (int i = 0; i < FAST_STEPS; i++) begin
            if (xe < h - FAST_STEP[i]) h = h - FAST_STEP[i];
          end
          h = h - LEV_ONE;
        end
        lvl_nxt = sat16(prod_t'(h));
        y       = lvl_nxt;
      end
      KIND_SMOOTH: begin
        // step grows by 8 each time the gap stays wide
        if (xe > h) begin
          if (xe > h + SMOOTH_GAP) begin
            c = c + 1'b1;
            h = h + lev_t'({c, 3'b000});
          end
          h = h + LEV_ONE;
        end else if (xe < h) begin
          if (xe < h - SMOOTH_GAP) begin
            c = c + 1'b1;
            h = h - lev_t'({c, 3'b000});
          end
          h = h - LEV_ONE;
        end
        if (c > CNT_WRAP) c = '0;
        cnt_nxt = c;
        lvl_nxt = sat16(prod_t'(h));
        y       = lvl_nxt;
      end
      default: begin
        y = xb_r;
      end
    endcase
    if (!ctl.act) y = xb_r;
  end

  // control and stage state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
      h0_r  <= '0;
      h1_r  <= '0;
      h2_r  <= '0;
      lvl_r <= '0;
      cnt_r <= '0;
    end else if (ctl.adv) begin
      va_r <= up.valid;
      vb_r <= va_r;
      if (vb_r && ctl.act) begin
        h0_r  <= h0_nxt;
        h1_r  <= h1_nxt;
        h2_r  <= h2_nxt;
        lvl_r <= lvl_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      xa_r <= up.x;
      xb_r <= xa_r;
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
    end
  end

  assign dn.valid = vb_r;
  assign dn.x     = y;
  assign a_busy   = va_r;

endmodule
`default_nettype wire

### design/configurable_sensor_filter_chain_unit.sv
// Top level: configuration registers, chain of filter cells, output register.
//
//  channel   dir  handshake     payload
//  in_word   in   valid/ready   sample_in  (16b signed)
//  out_word  out  valid/ready   sample_out (16b signed)
//  cfg_wr    in   valid/ready   index (8b), data (8b, low 3 bits used)
//
// A word enters only while the first cell has no word awaiting products:
// each cell forms its products, then finishes, and its history/level
// feedback must settle before the next word forms products. Reset clears
// cell state, configuration and valid flags. While the output register holds
// a word, the whole chain holds whenever its last cell has a word.
`timescale 1ns / 1ps
`default_nettype none
module configurable_sensor_filter_chain_unit #(
  parameter int NUM_STAGES = sfc_pkg::NUM_STAGES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sfc_in_if.sink    in_word,
  sfc_out_if.source out_word,
  sfc_cfg_if.sink   cfg_wr
);
  import sfc_pkg::*;

  localparam int NKIND = (NUM_STAGES < KIND_REGS) ? NUM_STAGES : KIND_REGS;

  used_t   stages_used_r;
  kind_t   kind_r [NKIND];
  kind_t   stage_kind [NUM_STAGES];
  tok_t    tok [NUM_STAGES];
  tok_t    in_tok;
  logic    a_busy0;
  logic    adv;
  logic    out_valid_r, out_valid_nxt;
  sample_t out_x_r;

  // configuration writes
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stages_used_r <= '0;
    end else if (cfg_wr.valid && cfg_wr.index == REG_STAGES_USED) begin
      stages_used_r <= cfg_wr.data[USED_W-1:0];
    end
  end

  for (genvar g = 0; g < NKIND; g++) begin : g_kind
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        kind_r[g] <= KIND_BYPASS;
      end else if (cfg_wr.valid && cfg_wr.index == REG_KIND_0 + CFG_IDX_W'(g)) begin
        kind_r[g] <= cfg_wr.data[KIND_W-1:0];
      end
    end
  end

  // chain moves unless its last word has no room in the output register
  assign adv = !(tok[NUM_STAGES-1].valid && out_valid_r);
  assign in_word.ready = adv && !a_busy0;
  assign in_tok.valid  = in_word.valid && in_word.ready;
  assign in_tok.x      = in_word.sample_in;

  // cells
  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cell
    localparam used_t IDX = USED_W'(g);
    cell_ctl_t ctl;
    logic      busy;

    if (g < NKIND) begin : g_cfg
      assign stage_kind[g] = kind_r[g];
    end else begin : g_fix
      assign stage_kind[g] = KIND_BYPASS;
    end

    assign ctl.adv  = adv;
    assign ctl.act  = (stages_used_r > IDX);
    assign ctl.kind = stage_kind[g];

    if (g == 0) begin : g_first
      sfc_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .up     (in_tok),
        .dn     (tok[g]),
        .a_busy (busy)
      );
      assign a_busy0 = busy;
    end else begin : g_rest
      sfc_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .up     (tok[g-1]),
        .dn     (tok[g]),
        .a_busy (busy)
      );
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_word.ready) out_valid_nxt = 1'b0;
    if (adv && tok[NUM_STAGES-1].valid) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tok[NUM_STAGES-1].valid) begin
      out_x_r <= tok[NUM_STAGES-1].x;
    end
  end

  assign out_word.valid      = out_valid_r;
  assign out_word.sample_out = out_x_r;

endmodule
`default_nettype wire

### bench/configurable_sensor_filter_chain_unit_tb.sv
// Testbench for the sensor filter chain: directed table, random phases, scoreboard.
`timescale 1ns / 1ps
module configurable_sensor_filter_chain_unit_tb;
  import sfc_pkg::*;

  localparam int N_STAGES = NUM_STAGES_DEF;

  // kind codes the block does not define; both behave as bypass
  localparam kind_t KIND_UNDEF_6 = 3'd6;
  localparam kind_t KIND_UNDEF_7 = 3'd7;

  // first register index past the kind registers
  localparam cfg_idx_t REG_FIRST_UNUSED = REG_KIND_0 + N_STAGES;

  localparam sample_t S_MAX = 16'sh7FFF;
  localparam sample_t S_MIN = 16'sh8000;

  // low-pass coefficients
  localparam longint CHEB_GAIN_IN = 3269048;
  localparam longint CHEB_GAIN_FB = 3701023;
  localparam longint CHEB_ROUND   = 1048576;
  localparam int     CHEB_SH_IN   = 2;
  localparam int     CHEB_SH_FB   = 3;
  localparam int     CHEB_SH_OUT  = 21;
  localparam longint BES_GAIN_IN  = 2057199;
  localparam longint BES_GAIN_FB  = 1068552;
  localparam longint BES_ROUND    = 524288;
  localparam int     BES_SH_IN    = 3;
  localparam int     BES_SH_FB    = 1;
  localparam int     BES_SH_OUT   = 20;

  // tracker constants
  localparam int FAST_STEP_SIZE [4] = '{512, 128, 32, 8};
  localparam int SMOOTH_GAP_LIM     = 8;
  localparam int SMOOTH_CNT_WRAP    = 10;

  // run shape
  localparam int  CLIMB_WORDS      = 720;
  localparam int  N_RAND_PHASES    = 7;
  localparam int  RAND_PHASE_WORDS = 100;
  localparam int  LONG_HOLD_CYCLES = 300;
  localparam int  DRAIN_LIMIT      = 4000;
  localparam int  TAIL_CYCLES      = 2 * N_STAGES + 12;
  localparam time TIMEOUT_NS       = 5_000_000;

  // one directed row; kinds are packed with stage 0 rightmost
  typedef struct packed {
    used_t                used;
    kind_t [N_STAGES-1:0] kinds;
    sample_t              x;
    logic                 known;
    sample_t              want;
  } dir_row_t;

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // straight after reset: zero stages in use, output equals input
    '{3'd0, {KIND_BYPASS, KIND_BYPASS, KIND_BYPASS, KIND_BYPASS}, S_MAX, 1'b1, S_MAX},
    '{3'd0, {KIND_BYPASS, KIND_BYPASS, KIND_BYPASS, KIND_BYPASS}, S_MIN, 1'b1, S_MIN},
    '{3'd0, {KIND_BYPASS, KIND_BYPASS, KIND_BYPASS, KIND_BYPASS}, 16'sd0, 1'b1, 16'sd0},
    '{3'd0, {KIND_BYPASS, KIND_BYPASS, KIND_BYPASS, KIND_BYPASS}, -16'sd1, 1'b1, -16'sd1},
    // stage count above the chain length, undefined kinds pass through
    '{3'd7, {KIND_UNDEF_7, KIND_UNDEF_6, KIND_BYPASS, KIND_BYPASS},
      16'sd21845, 1'b1, 16'sd21845},
    '{3'd7, {KIND_UNDEF_7, KIND_UNDEF_6, KIND_BYPASS, KIND_BYPASS},
      -16'sd21846, 1'b1, -16'sd21846},
    // chebyshev at full scale
    '{3'd1, {KIND_BYPASS, KIND_BYPASS, KIND_BYPASS, KIND_CHEB}, S_MAX, 1'b0, 16'sd0},
    '{3'd1, {KIND_BYPASS, KIND_BYPASS, KIND_BYPASS, KIND_CHEB}, S_MAX, 1'b0, 16'sd0},
    '{3'd1, {KIND_BYPASS, KIND_BYPASS, KIND_BYPASS, KIND_CHEB}, S_MIN, 1'b0, 16'sd0},
    // bessel at full scale
    '{3'd1, {KIND_BYPASS, KIND_BYPASS, KIND_BYPASS, KIND_BESSEL}, S_MIN, 1'b0, 16'sd0},
    '{3'd1, {KIND_BYPASS, KIND_BYPASS, KIND_BYPASS, KIND_BESSEL}, S_MAX, 1'b0, 16'sd0},
    '{3'd1, {KIND_BYPASS, KIND_BYPASS, KIND_BYPASS, KIND_BESSEL}, S_MAX, 1'b0, 16'sd0},
    // median over history left by the low-pass
    '{3'd1, {KIND_BYPASS, KIND_BYPASS, KIND_BYPASS, KIND_MEDIAN}, 16'sd100, 1'b0, 16'sd0},
    '{3'd1, {KIND_BYPASS, KIND_BYPASS, KIND_BYPASS, KIND_MEDIAN}, -16'sd50, 1'b0, 16'sd0},
    '{3'd1, {KIND_BYPASS, KIND_BYPASS, KIND_BYPASS, KIND_MEDIAN}, 16'sd300, 1'b0, 16'sd0},
    // fast tracker, big swings
    '{3'd1, {KIND_BYPASS, KIND_BYPASS, KIND_BYPASS, KIND_FAST}, S_MAX, 1'b0, 16'sd0},
    '{3'd1, {KIND_BYPASS, KIND_BYPASS, KIND_BYPASS, KIND_FAST}, S_MIN, 1'b0, 16'sd0},
    '{3'd1, {KIND_BYPASS, KIND_BYPASS, KIND_BYPASS, KIND_FAST}, 16'sd5, 1'b0, 16'sd0},
    // smooth tracker, growing step
    '{3'd1, {KIND_BYPASS, KIND_BYPASS, KIND_BYPASS, KIND_SMOOTH}, S_MAX, 1'b0, 16'sd0},
    '{3'd1, {KIND_BYPASS, KIND_BYPASS, KIND_BYPASS, KIND_SMOOTH}, S_MAX, 1'b0, 16'sd0},
    '{3'd1, {KIND_BYPASS, KIND_BYPASS, KIND_BYPASS, KIND_SMOOTH}, S_MIN, 1'b0, 16'sd0},
    // full chain, then shorter chains that leave later stages untouched
    '{3'd4, {KIND_SMOOTH, KIND_FAST, KIND_BESSEL, KIND_CHEB}, 16'sd12000, 1'b0, 16'sd0},
    '{3'd4, {KIND_SMOOTH, KIND_FAST, KIND_BESSEL, KIND_CHEB}, -16'sd12000, 1'b0, 16'sd0},
    '{3'd2, {KIND_MEDIAN, KIND_MEDIAN, KIND_BESSEL, KIND_CHEB}, 16'sd777, 1'b0, 16'sd0},
    '{3'd3, {KIND_MEDIAN, KIND_MEDIAN, KIND_BESSEL, KIND_CHEB}, S_MIN, 1'b0, 16'sd0}
  };

  logic clk;
  logic rst_n;

  sfc_in_if  in_if ();
  sfc_out_if out_if ();
  sfc_cfg_if cfg_if ();

  configurable_sensor_filter_chain_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_if),
    .out_word (out_if),
    .cfg_wr   (cfg_if)
  );

  // chain state as the block should hold it
  sample_t              hist [3*N_STAGES];
  sample_t              level [N_STAGES];
  cnt_t                 step_cnt [N_STAGES];
  used_t                cur_used;
  kind_t [N_STAGES-1:0] cur_kind;

  sample_t expected_samples [$];
  int      errors;
  bit      quiet;
  bit      long_hold_req;

  // typed expectation travels with the word, driven like the payload
  logic    dir_known;
  sample_t dir_value;

  sample_t chk_want;
  sample_t chk_pred;

  initial begin
    for (int i = 0; i < 3*N_STAGES; i++) hist[i] = '0;
    for (int i = 0; i < N_STAGES; i++) begin
      level[i] = '0;
      step_cnt[i] = '0;
    end
    cur_used = '0;
    cur_kind = '0;
    errors = 0;
    quiet = 1'b0;
    long_hold_req = 1'b0;
  end

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic sample_t clamp16(longint v);
    if (v > 32767) return S_MAX;
    if (v < -32768) return S_MIN;
    return sample_t'(v);
  endfunction

  // first-order low-pass: v0 takes v1, v1 gets the new filtered value
  function automatic sample_t lowpass_step(int s, sample_t x, longint ka, int sa,
                                           longint kb, int sb, longint rnd, int sr);
    longint acc;
    hist[3*s] = hist[3*s+1];
    acc = ((longint'(x) * ka) >>> sa) + ((longint'(hist[3*s]) * kb) >>> sb) + rnd;
    hist[3*s+1] = clamp16(acc >>> sr);
    return clamp16(longint'(hist[3*s]) + longint'(hist[3*s+1]));
  endfunction

  function automatic sample_t median_step(int s, sample_t x);
    sample_t a, b, c;
    hist[3*s]   = hist[3*s+1];
    hist[3*s+1] = hist[3*s+2];
    hist[3*s+2] = x;
    a = hist[3*s];
    b = hist[3*s+1];
    c = hist[3*s+2];
    if ((a <= b && b <= c) || (c <= b && b <= a)) return b;
    if ((b <= a && a <= c) || (c <= a && a <= b)) return a;
    return c;
  endfunction

  function automatic sample_t fast_track_step(int s, sample_t x);
    int h, xv;
    h = int'(level[s]);
    xv = int'(x);
    if (xv > h) begin
      for (int i = 0; i < 4; i++)
        if (xv > h + FAST_STEP_SIZE[i]) h += FAST_STEP_SIZE[i];
      h++;
    end else if (xv < h) begin
      for (int i = 0; i < 4; i++)
        if (xv < h - FAST_STEP_SIZE[i]) h -= FAST_STEP_SIZE[i];
      h--;
    end
    level[s] = clamp16(longint'(h));
    return level[s];
  endfunction

  function automatic sample_t smooth_track_step(int s, sample_t x);
    longint h, xv;
    int c;
    h = longint'(level[s]);
    xv = longint'(x);
    c = int'(step_cnt[s]);
    if (xv > h) begin
      if (xv > h + SMOOTH_GAP_LIM) begin
        c++;
        h += 8 * c;
      end
      h++;
    end else if (xv < h) begin
      if (xv < h - SMOOTH_GAP_LIM) begin
        c++;
        h -= 8 * c;
      end
      h--;
    end
    if (c > SMOOTH_CNT_WRAP) c = 0;
    step_cnt[s] = cnt_t'(c);
    level[s] = clamp16(h);
    return level[s];
  endfunction

  // run one sample through the stages in use
  function automatic sample_t filter_chain_next(sample_t x_in);
    sample_t x;
    int n;
    x = x_in;
    n = (int'(cur_used) > N_STAGES) ? N_STAGES : int'(cur_used);
    for (int i = 0; i < n; i++) begin
      case (cur_kind[i])
        KIND_CHEB: begin
          x = lowpass_step(i, x, CHEB_GAIN_IN, CHEB_SH_IN, CHEB_GAIN_FB, CHEB_SH_FB,
                           CHEB_ROUND, CHEB_SH_OUT);
        end
        KIND_BESSEL: begin
          x = lowpass_step(i, x, BES_GAIN_IN, BES_SH_IN, BES_GAIN_FB, BES_SH_FB,
                           BES_ROUND, BES_SH_OUT);
        end
        KIND_MEDIAN: x = median_step(i, x);
        KIND_FAST:   x = fast_track_step(i, x);
        KIND_SMOOTH: x = smooth_track_step(i, x);
        default: ;
      endcase
    end
    return x;
  endfunction

  // scoreboard: check the result word first, then record the accepted input word
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_samples.size() == 0) begin
          errors++;
          $error("sample_out: expected no word, got %0d", out_if.sample_out);
        end else begin
          chk_want = expected_samples.pop_front();
          if (out_if.sample_out !== chk_want) begin
            errors++;
            $error("sample_out: expected %0d, got %0d", chk_want, out_if.sample_out);
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        chk_pred = filter_chain_next(in_if.sample_in);
        expected_samples.push_back(dir_known ? dir_value : chk_pred);
      end
    end
  end

  // receiver: random stall bursts, one long hold on request
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_if.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // offer one word, optionally after an idle burst, and wait until it is taken
  task automatic push_word(sample_t x, logic known, sample_t want);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.sample_in <= x;
    dir_known       <= known;
    dir_value       <= want;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic close_input();
    in_if.valid <= 1'b0;
    dir_known   <= 1'b0;
  endtask

  // a clock edge first so the scoreboard has recorded the last accepted word
  task automatic wait_drained();
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
  endtask

  // valid stays high across back-to-back writes; caller lowers it
  task automatic cfg_write(cfg_idx_t idx, cfg_data_t d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == REG_STAGES_USED) begin
      cur_used = used_t'(d);
    end else if (idx >= REG_KIND_0 && idx < REG_FIRST_UNUSED) begin
      cur_kind[idx - REG_KIND_0] = kind_t'(d);
    end
  endtask

  // write every register with junk in the unused data bits, plus a stray index
  task automatic program_chain(used_t used, kind_t [N_STAGES-1:0] kinds);
    cfg_write(REG_STAGES_USED, {5'($urandom), used});
    for (int i = 0; i < N_STAGES; i++)
      cfg_write(cfg_idx_t'(REG_KIND_0 + i), {5'($urandom), kinds[i]});
    cfg_write(cfg_idx_t'($urandom_range(REG_FIRST_UNUSED, 255)), cfg_data_t'($urandom));
    cfg_if.valid <= 1'b0;
  endtask

  function automatic kind_t pick_kind();
    if ($urandom_range(0, 7) == 0) return kind_t'($urandom_range(0, 7));
    return kind_t'($urandom_range(KIND_CHEB, KIND_SMOOTH));
  endfunction

  // random sample shapes: noise, slow wander near a base, extremes, a held base, flips
  function automatic sample_t make_sample(int mode, sample_t base);
    case (mode)
      0, 1, 2: return sample_t'($urandom);
      3, 4, 5: return clamp16(longint'(base) + longint'($urandom_range(0, 64)) - 32);
      6:       return ($urandom_range(0, 1) != 0) ? S_MAX : S_MIN;
      7:       return base;
      default: return ($urandom_range(0, 1) != 0) ? ~base : base;
    endcase
  endfunction

  initial begin
    kind_t [N_STAGES-1:0] kinds;
    used_t   used;
    sample_t base;
    int      mode, seg, n, k;

    in_if.valid     <= 1'b0;
    in_if.sample_in <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= '0;
    cfg_if.data     <= '0;
    dir_known       <= 1'b0;
    dir_value       <= '0;
    rst_n           <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; reprogram only when a row changes the chain
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TAB[r].used != cur_used || DIR_TAB[r].kinds != cur_kind) begin
        close_input();
        wait_drained();
        program_chain(DIR_TAB[r].used, DIR_TAB[r].kinds);
      end
      push_word(DIR_TAB[r].x, DIR_TAB[r].known, DIR_TAB[r].want);
    end

    // smooth tracker first, held near full scale long enough to overshoot
    close_input();
    wait_drained();
    kinds[0] = KIND_SMOOTH;
    for (int i = 1; i < N_STAGES; i++) kinds[i] = pick_kind();
    program_chain(3'd4, kinds);
    for (int i = 0; i < CLIMB_WORDS; i++) begin
      if ($urandom_range(0, 15) == 0)
        push_word(sample_t'(32767 - $urandom_range(0, 20)), 1'b0, '0);
      else
        push_word(S_MAX, 1'b0, '0);
    end

    // random chains and signal shapes; one phase with a long receiver hold,
    // the last with no idling at all
    for (int p = 0; p < N_RAND_PHASES; p++) begin
      close_input();
      wait_drained();
      case (p)
        0:       used = 3'd4;
        1:       used = 3'd7;
        2:       used = 3'd0;
        default: used = used_t'($urandom_range(1, 7));
      endcase
      for (int i = 0; i < N_STAGES; i++) kinds[i] = pick_kind();
      if (p == N_RAND_PHASES - 1) quiet = 1'b1;
      program_chain(used, kinds);
      if (p == 1) long_hold_req = 1'b1;
      n = 0;
      while (n < RAND_PHASE_WORDS) begin
        mode = $urandom_range(0, 9);
        seg  = $urandom_range(8, 30);
        base = sample_t'($urandom);
        for (k = 0; k < seg && n < RAND_PHASE_WORDS; k++) begin
          push_word(make_sample(mode, base), 1'b0, '0);
          n++;
        end
      end
    end

    // drain, then let the pipeline settle
    close_input();
    for (k = 0; k < DRAIN_LIMIT && expected_samples.size() != 0; k++) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_samples.size() != 0) begin
      errors++;
      $error("sample_out: %0d expected words never arrived", expected_samples.size());
    end
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // hard stop
  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### configurable_sensor_filter_chain_unit.f
design/sfc_pkg.sv
design/sfc_if.sv
design/sfc_cell.sv
design/configurable_sensor_filter_chain_unit.sv
bench/configurable_sensor_filter_chain_unit_tb.sv
